FILE: hdl/bizu_pkg.sv
// ----------------------------------------------------------------------------
// bizu_pkg
// Shared types and constants of the bilinear image zoom unit: transfer
// payloads, configuration register map and pipeline metadata.
// ----------------------------------------------------------------------------
package bizu_pkg;

    // Request function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // Saturation limit of an output pixel
    localparam logic [7:0] PIX_MAX = 8'd255;

    // Configuration register map
    typedef enum logic [2:0] {
        CFG_INV_ZOOM_X   = 3'd0,
        CFG_INV_ZOOM_Y   = 3'd1,
        CFG_ROI_LEFT     = 3'd2,
        CFG_ROI_TOP      = 3'd3,
        CFG_ROI_RIGHT    = 3'd4,
        CFG_ROI_BOTTOM   = 3'd5,
        CFG_IMAGE_WIDTH  = 3'd6,
        CFG_IMAGE_HEIGHT = 3'd7
    } cfg_index_t;

    // Register reset values
    localparam logic [23:0] RST_INV_ZOOM = 24'd65536;
    localparam logic [8:0]  RST_ROI_LO   = 9'd0;
    localparam logic [8:0]  RST_ROI_HI   = 9'd511;
    localparam logic [9:0]  RST_IMG_SIZE = 10'd512;

    // Request transfer payload
    typedef struct packed {
        logic       func;
        logic [8:0] col;
        logic [8:0] row;
        logic [7:0] pixel_in;
    } req_t;

    // Result transfer payload
    typedef struct packed {
        logic [7:0] out_pixel;
        logic [8:0] out_col;
        logic [8:0] out_row;
    } rsp_t;

    // Configuration register file contents
    typedef struct packed {
        logic [23:0] inv_zoom_x;
        logic [23:0] inv_zoom_y;
        logic [8:0]  roi_left;
        logic [8:0]  roi_top;
        logic [8:0]  roi_right;
        logic [8:0]  roi_bottom;
        logic [9:0]  image_width;
        logic [9:0]  image_height;
    } cfg_t;

    // Metadata of a read request travelling with its memory access
    typedef struct packed {
        logic       vld;
        logic       zero;
        logic [7:0] p;
        logic [7:0] q;
        logic [8:0] col;
        logic [8:0] row;
    } stage_t;

endpackage

FILE: hdl/bizu_ram.sv
// ----------------------------------------------------------------------------
// bizu_ram
// Generic synchronous RAM: one write port, two read ports, registered read
// data with read enable (read-first on address collision).
// ----------------------------------------------------------------------------
module bizu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 262144
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    // Storage and registered reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= ram_reg[raddr_a];
            rdata_b_reg <= ram_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

FILE: hdl/bizu_cfg.sv
// ----------------------------------------------------------------------------
// bizu_cfg
// Configuration register file: takes register write transfers and holds
// zoom factors, region of interest and image size.
// ----------------------------------------------------------------------------
module bizu_cfg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    output bizu_pkg::cfg_t     cfg
);

    import bizu_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always taken
    assign cfg_ready = 1'b1;

    // Register update
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_INV_ZOOM_X:   cfg_next.inv_zoom_x   = cfg_data;
                CFG_INV_ZOOM_Y:   cfg_next.inv_zoom_y   = cfg_data;
                CFG_ROI_LEFT:     cfg_next.roi_left     = cfg_data[8:0];
                CFG_ROI_TOP:      cfg_next.roi_top      = cfg_data[8:0];
                CFG_ROI_RIGHT:    cfg_next.roi_right    = cfg_data[8:0];
                CFG_ROI_BOTTOM:   cfg_next.roi_bottom   = cfg_data[8:0];
                CFG_IMAGE_WIDTH:  cfg_next.image_width  = cfg_data[9:0];
                CFG_IMAGE_HEIGHT: cfg_next.image_height = cfg_data[9:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inv_zoom_x   <= RST_INV_ZOOM;
            cfg_reg.inv_zoom_y   <= RST_INV_ZOOM;
            cfg_reg.roi_left     <= RST_ROI_LO;
            cfg_reg.roi_top      <= RST_ROI_LO;
            cfg_reg.roi_right    <= RST_ROI_HI;
            cfg_reg.roi_bottom   <= RST_ROI_HI;
            cfg_reg.image_width  <= RST_IMG_SIZE;
            cfg_reg.image_height <= RST_IMG_SIZE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/bizu_addr.sv
// ----------------------------------------------------------------------------
// bizu_addr
// Request stage: source position multiply and region test on accept, then
// neighbor address generation with edge clamp and pixel store writes.
// ----------------------------------------------------------------------------
module bizu_addr #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bizu_pkg::cfg_t       cfg,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  bizu_pkg::req_t       req,
    input  logic                 load_c,
    output logic                 mem_we,
    output logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)-1:0] mem_waddr,
    output logic [7:0]           mem_wdata,
    output logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)-1:0] top_addr_a,
    output logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)-1:0] top_addr_b,
    output logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)-1:0] bot_addr_a,
    output logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)-1:0] bot_addr_b,
    output bizu_pkg::stage_t     b_meta
);

    import bizu_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);

    logic          accept;
    logic          load_b;
    logic [XW-1:0] wm1;
    logic [YW-1:0] hm1;
    logic          roi_ok;
    logic [32:0]   sx;
    logic [32:0]   sy;

    logic          b_vld_reg;
    logic          b_vld_next;
    req_t          b_item_reg;
    logic          b_roi_ok_reg;
    logic [32:0]   b_sx_reg;
    logic [32:0]   b_sy_reg;

    logic [16:0]   xi_full;
    logic [16:0]   yi_full;
    logic          past_x;
    logic          past_y;
    logic [XW-1:0] xi;
    logic [YW-1:0] yi;
    logic [XW-1:0] xn;
    logic [YW-1:0] yn;
    logic          col_ok;
    logic          row_ok;

    // Stage flow: B moves on when C takes it
    assign load_b    = !b_vld_reg || load_c;
    assign req_ready = load_b;
    assign accept    = req_valid && load_b;

    // Last valid column and row, size saturated to 1..MAX
    always_comb
    begin
        if (cfg.image_width == '0)
        begin
            wm1 = '0;
        end
        else if (32'(cfg.image_width) > MAX_WIDTH)
        begin
            wm1 = XW'(MAX_WIDTH - 1);
        end
        else
        begin
            wm1 = XW'(cfg.image_width - 10'd1);
        end

        if (cfg.image_height == '0)
        begin
            hm1 = '0;
        end
        else if (32'(cfg.image_height) > MAX_HEIGHT)
        begin
            hm1 = YW'(MAX_HEIGHT - 1);
        end
        else
        begin
            hm1 = YW'(cfg.image_height - 10'd1);
        end
    end

    // Region of interest test, right and bottom clamped to the image
    assign roi_ok = (req.col >= cfg.roi_left) && (req.col <= cfg.roi_right) &&
                    (32'(req.col) <= 32'(wm1)) &&
                    (req.row >= cfg.roi_top) && (req.row <= cfg.roi_bottom) &&
                    (32'(req.row) <= 32'(hm1));

    // Source position in Q17.16
    assign sx = 33'(req.col) * 33'(cfg.inv_zoom_x);
    assign sy = 33'(req.row) * 33'(cfg.inv_zoom_y);

    assign b_vld_next = load_b ? accept : b_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
        end
        else
        begin
            b_vld_reg <= b_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_item_reg   <= req;
            b_roi_ok_reg <= roi_ok;
            b_sx_reg     <= sx;
            b_sy_reg     <= sy;
        end
    end

    // Integer position, past-image test and neighbor clamp
    assign xi_full = b_sx_reg[32:16];
    assign yi_full = b_sy_reg[32:16];
    assign past_x  = 32'(xi_full) > 32'(wm1);
    assign past_y  = 32'(yi_full) > 32'(hm1);
    assign xi      = XW'(xi_full);
    assign yi      = YW'(yi_full);
    assign xn      = (xi == wm1) ? xi : xi + XW'(1);
    assign yn      = (yi == hm1) ? yi : yi + YW'(1);

    // Neighbor addresses: top pair on one copy, bottom pair on the other
    assign top_addr_a = {yi, xi};
    assign top_addr_b = {yi, xn};
    assign bot_addr_a = {yn, xi};
    assign bot_addr_b = {yn, xn};

    // Pixel store write, issued in order with the reads
    assign col_ok    = 32'(b_item_reg.col) < MAX_WIDTH;
    assign row_ok    = 32'(b_item_reg.row) < MAX_HEIGHT;
    assign mem_we    = load_c && b_vld_reg && (b_item_reg.func == FUNC_WRITE) &&
                       col_ok && row_ok;
    assign mem_waddr = {YW'(b_item_reg.row), XW'(b_item_reg.col)};
    assign mem_wdata = b_item_reg.pixel_in;

    // Metadata for the blend stages
    always_comb
    begin
        b_meta.vld  = b_vld_reg && (b_item_reg.func == FUNC_READ);
        b_meta.zero = !b_roi_ok_reg || past_x || past_y;
        b_meta.p    = b_sx_reg[15:8];
        b_meta.q    = b_sy_reg[15:8];
        b_meta.col  = b_item_reg.col;
        b_meta.row  = b_item_reg.row;
    end

endmodule

FILE: hdl/bizu_blend.sv
// ----------------------------------------------------------------------------
// bizu_blend
// Bilinear blend of the four neighbors: horizontal weights, then vertical
// weights, truncate and saturate, and the result output register.
// ----------------------------------------------------------------------------
module bizu_blend (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bizu_pkg::stage_t     b_meta,
    output logic                 load_c,
    input  logic [7:0]           pix_a,
    input  logic [7:0]           pix_b,
    input  logic [7:0]           pix_c,
    input  logic [7:0]           pix_d,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output bizu_pkg::rsp_t       rsp
);

    import bizu_pkg::*;

    logic        load_d;
    logic        load_o;

    stage_t      c_meta_reg;
    stage_t      c_meta_next;
    logic [8:0]  wp;
    logic [16:0] h0_full;
    logic [16:0] h1_full;

    logic        d_vld_reg;
    logic        d_vld_next;
    logic        d_zero_reg;
    logic [7:0]  d_q_reg;
    logic [15:0] d_h0_reg;
    logic [15:0] d_h1_reg;
    logic [8:0]  d_col_reg;
    logic [8:0]  d_row_reg;

    logic [8:0]  wq;
    logic [24:0] sum;
    logic [8:0]  v9;
    logic [7:0]  pix;

    logic        rsp_vld_reg;
    logic        rsp_vld_next;
    rsp_t        rsp_reg;

    // Stage flow, output register parts the two sides
    assign load_o = !rsp_vld_reg || rsp_ready;
    assign load_d = !d_vld_reg || load_o;
    assign load_c = !c_meta_reg.vld || load_d;

    // Stage C metadata (memory data arrives alongside)
    always_comb
    begin
        c_meta_next = c_meta_reg;
        if (load_c)
        begin
            c_meta_next = b_meta;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_meta_reg <= '0;
        end
        else
        begin
            c_meta_reg <= c_meta_next;
        end
    end

    // Horizontal blend of each row pair
    assign wp      = 9'd256 - {1'b0, c_meta_reg.p};
    assign h0_full = 17'(wp) * 17'(pix_a) + 17'(c_meta_reg.p) * 17'(pix_b);
    assign h1_full = 17'(wp) * 17'(pix_c) + 17'(c_meta_reg.p) * 17'(pix_d);

    assign d_vld_next = load_d ? c_meta_reg.vld : d_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg <= 1'b0;
        end
        else
        begin
            d_vld_reg <= d_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_d)
        begin
            d_zero_reg <= c_meta_reg.zero;
            d_q_reg    <= c_meta_reg.q;
            d_h0_reg   <= h0_full[15:0];
            d_h1_reg   <= h1_full[15:0];
            d_col_reg  <= c_meta_reg.col;
            d_row_reg  <= c_meta_reg.row;
        end
    end

    // Vertical blend, truncate, saturate
    assign wq  = 9'd256 - {1'b0, d_q_reg};
    assign sum = 25'(wq) * 25'(d_h0_reg) + 25'(d_q_reg) * 25'(d_h1_reg);
    assign v9  = sum[24:16];

    always_comb
    begin
        if (d_zero_reg)
        begin
            pix = '0;
        end
        else if (v9 > 9'(PIX_MAX))
        begin
            pix = PIX_MAX;
        end
        else
        begin
            pix = v9[7:0];
        end
    end

    // Result register
    assign rsp_vld_next = load_o ? d_vld_reg : rsp_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_o)
        begin
            rsp_reg.out_pixel <= pix;
            rsp_reg.out_col   <= d_col_reg;
            rsp_reg.out_row   <= d_row_reg;
        end
    end

    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: hdl/bilinear_image_zoom_unit.sv
// ----------------------------------------------------------------------------
// bilinear_image_zoom_unit
// Bilinear image zoom: source pixels are written into an on-chip store,
// read requests return one interpolated pixel each.
// ----------------------------------------------------------------------------
// Pipeline: stage B, stage C (memory read), stage D and the result register.
// Throughput: one request (read or write) per clock unless stalled; the four
//   neighbors are read at once from twin pixel store copies, two ports each.
// Reset: control and configuration registers return to defaults at once;
//   the pixel store is not cleared and holds undefined data until written.
module bilinear_image_zoom_unit #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  bizu_pkg::req_t     req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output bizu_pkg::rsp_t     rsp,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data
);

    import bizu_pkg::*;

    localparam int AW    = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT);
    localparam int DEPTH = 1 << AW;

    cfg_t          cfg;
    stage_t        b_meta;
    logic          load_c;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] top_addr_a;
    logic [AW-1:0] top_addr_b;
    logic [AW-1:0] bot_addr_a;
    logic [AW-1:0] bot_addr_b;
    logic [7:0]    pix_a;
    logic [7:0]    pix_b;
    logic [7:0]    pix_c;
    logic [7:0]    pix_d;

    // Configuration registers
    bizu_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Position and address generation
    bizu_addr #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_addr (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .load_c     (load_c),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .top_addr_a (top_addr_a),
        .top_addr_b (top_addr_b),
        .bot_addr_a (bot_addr_a),
        .bot_addr_b (bot_addr_b),
        .b_meta     (b_meta)
    );

    // Pixel store copy for the upper neighbor pair
    bizu_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram_top (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .re      (load_c),
        .raddr_a (top_addr_a),
        .raddr_b (top_addr_b),
        .rdata_a (pix_a),
        .rdata_b (pix_b)
    );

    // Pixel store copy for the lower neighbor pair
    bizu_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram_bot (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .re      (load_c),
        .raddr_a (bot_addr_a),
        .raddr_b (bot_addr_b),
        .rdata_a (pix_c),
        .rdata_b (pix_d)
    );

    // Blend and result register
    bizu_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .b_meta    (b_meta),
        .load_c    (load_c),
        .pix_a     (pix_a),
        .pix_b     (pix_b),
        .pix_c     (pix_c),
        .pix_d     (pix_d),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

FILE: verif/bizu_zoom_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bizu_zoom_checker
// Watches the request, result and configuration channels of the bilinear
// zoom unit, keeps its own copy of the source image and the registers,
// works out each requested pixel and compares it with the returned transfer.
// ----------------------------------------------------------------------------
module bizu_zoom_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic             req_ready,
    input  bizu_pkg::req_t   req,
    input  logic             rsp_valid,
    input  logic             rsp_ready,
    input  bizu_pkg::rsp_t   rsp,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [23:0]      cfg_data,
    input  logic             run_done,
    output int               errors
);

    import bizu_pkg::*;

    localparam int STORE_DIM = 512;

    logic [7:0] src_pixels [0:STORE_DIM*STORE_DIM-1];
    cfg_t       zoom_cfg;
    rsp_t       pixel_due_q [$];
    bit         end_checked;

    initial errors = 0;

    // Size registers saturate to 1..STORE_DIM
    function automatic logic [9:0] clamp_size(input logic [9:0] v);
        if (v == 10'd0)
            return 10'd1;
        if (v > 10'(STORE_DIM))
            return 10'(STORE_DIM);
        return v;
    endfunction

    // Expected output pixel for a request at (c, r) under the current registers
    function automatic logic [7:0] zoomed_pixel(input logic [8:0] c, input logic [8:0] r);
        logic [9:0]  last_c;
        logic [9:0]  last_r;
        logic [9:0]  right;
        logic [9:0]  bottom;
        logic [32:0] sx;
        logic [32:0] sy;
        logic [16:0] xi;
        logic [16:0] yi;
        logic [16:0] xn;
        logic [16:0] yn;
        int unsigned p;
        int unsigned q;
        int unsigned a;
        int unsigned b;
        int unsigned lc;
        int unsigned d;
        int unsigned acc;
        last_c = clamp_size(zoom_cfg.image_width) - 10'd1;
        last_r = clamp_size(zoom_cfg.image_height) - 10'd1;
        right  = (zoom_cfg.roi_right < last_c) ? 10'(zoom_cfg.roi_right) : last_c;
        bottom = (zoom_cfg.roi_bottom < last_r) ? 10'(zoom_cfg.roi_bottom) : last_r;
        // outside the clamped region of interest, or empty region
        if (c < zoom_cfg.roi_left || c > right || r < zoom_cfg.roi_top || r > bottom)
            return 8'd0;
        sx = 33'(c) * 33'(zoom_cfg.inv_zoom_x);
        sy = 33'(r) * 33'(zoom_cfg.inv_zoom_y);
        xi = sx[32:16];
        yi = sy[32:16];
        // source position lands past the image
        if (xi > 17'(last_c) || yi > 17'(last_r))
            return 8'd0;
        p  = 32'(sx[15:8]);
        q  = 32'(sy[15:8]);
        // right and lower neighbors stick to the last column / row
        xn = (xi + 17'd1 > 17'(last_c)) ? 17'(last_c) : xi + 17'd1;
        yn = (yi + 17'd1 > 17'(last_r)) ? 17'(last_r) : yi + 17'd1;
        a  = 32'(src_pixels[{yi[8:0], xi[8:0]}]);
        b  = 32'(src_pixels[{yi[8:0], xn[8:0]}]);
        lc = 32'(src_pixels[{yn[8:0], xi[8:0]}]);
        d  = 32'(src_pixels[{yn[8:0], xn[8:0]}]);
        acc = ((256 - q) * ((256 - p) * a + p * b) + q * ((256 - p) * lc + p * d)) >> 16;
        if (acc > 32'(PIX_MAX))
            return PIX_MAX;
        return acc[7:0];
    endfunction

    function automatic void flag_field(input string field, input logic [8:0] c,
                                       input logic [8:0] r, input int unsigned want,
                                       input int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch for pixel (%0d,%0d): expected %0d, got %0d",
                     $time, field, c, r, want, got);
        end
    endfunction

    // Register shadow
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zoom_cfg.inv_zoom_x   <= RST_INV_ZOOM;
            zoom_cfg.inv_zoom_y   <= RST_INV_ZOOM;
            zoom_cfg.roi_left     <= RST_ROI_LO;
            zoom_cfg.roi_top      <= RST_ROI_LO;
            zoom_cfg.roi_right    <= RST_ROI_HI;
            zoom_cfg.roi_bottom   <= RST_ROI_HI;
            zoom_cfg.image_width  <= RST_IMG_SIZE;
            zoom_cfg.image_height <= RST_IMG_SIZE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_INV_ZOOM_X:   zoom_cfg.inv_zoom_x   <= cfg_data;
                CFG_INV_ZOOM_Y:   zoom_cfg.inv_zoom_y   <= cfg_data;
                CFG_ROI_LEFT:     zoom_cfg.roi_left     <= cfg_data[8:0];
                CFG_ROI_TOP:      zoom_cfg.roi_top      <= cfg_data[8:0];
                CFG_ROI_RIGHT:    zoom_cfg.roi_right    <= cfg_data[8:0];
                CFG_ROI_BOTTOM:   zoom_cfg.roi_bottom   <= cfg_data[8:0];
                CFG_IMAGE_WIDTH:  zoom_cfg.image_width  <= cfg_data[9:0];
                CFG_IMAGE_HEIGHT: zoom_cfg.image_height <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // Image shadow, prediction and comparison
    always @(posedge clk)
    begin
        rsp_t due;
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                if (req.func == FUNC_WRITE)
                    src_pixels[{req.row, req.col}] = req.pixel_in;
                else
                begin
                    due.out_pixel = zoomed_pixel(req.col, req.row);
                    due.out_col   = req.col;
                    due.out_row   = req.row;
                    pixel_due_q.push_back(due);
                end
            end

            if (rsp_valid && rsp_ready)
            begin
                if (pixel_due_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result for (%0d,%0d) value %0d with nothing expected",
                             $time, rsp.out_col, rsp.out_row, rsp.out_pixel);
                end
                else
                begin
                    due = pixel_due_q.pop_front();
                    flag_field("out_pixel", due.out_col, due.out_row,
                               32'(due.out_pixel), 32'(rsp.out_pixel));
                    flag_field("out_col", due.out_col, due.out_row,
                               32'(due.out_col), 32'(rsp.out_col));
                    flag_field("out_row", due.out_col, due.out_row,
                               32'(due.out_row), 32'(rsp.out_row));
                end
            end

            // anything still queued at the end never came back
            if (run_done && !end_checked)
            begin
                end_checked = 1'b1;
                if (pixel_due_q.size() != 0)
                begin
                    $display("%0t: %0d expected results never arrived",
                             $time, pixel_due_q.size());
                    errors += pixel_due_q.size();
                end
            end
        end
    end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the bilinear image zoom unit: a short directed part over the
// edge and region cases, then phases of random register settings with mostly
// reads whose source neighbors are written first, plus random writes and
// noise. Both channels idle at random; the result side holds off for long
// stretches now and then so the unit backs up.
// ----------------------------------------------------------------------------
module tb_top;

    import bizu_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    req_t        req;
    logic        rsp_valid;
    logic        rsp_ready;
    rsp_t        rsp;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;
    logic        run_done;
    int          fail_count;

    cfg_t        live_cfg;
    bit          src_written [0:262143];
    int          reads_sent  = 0;
    int          pixels_back = 0;
    int          phase_items = 0;
    bit          steady_phase = 1'b0;

    bilinear_image_zoom_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bizu_zoom_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .run_done  (run_done),
        .errors    (fail_count)
    );

    // Clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Run limit
    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // Count result transfers
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            pixels_back <= pixels_back + 1;
    end

    // Result side: random ready, with a long hold-off every 40 runs
    initial
    begin : rsp_ready_gen
        int runs;
        int len;
        runs = 0;
        rsp_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            runs++;
            rsp_ready <= 1'b1;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
            repeat (len) @(posedge clk);
            if (runs % 40 == 10)
                len = 300;
            else if ($urandom_range(0, 9) == 0)
                len = $urandom_range(10, 40);
            else
                len = $urandom_range(1, 3);
            rsp_ready <= 1'b0;
            repeat (len) @(posedge clk);
        end
    end

    function automatic int eff_size(input logic [9:0] v);
        if (v == 10'd0)
            return 1;
        if (v > 10'd512)
            return 512;
        return int'(v);
    endfunction

    function automatic int pick_gap();
        int roll;
        if (steady_phase)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [9:0] pick_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return 10'd0;
        if (roll < 6)
            return 10'($urandom_range(513, 1023));
        if (roll < 55)
            return 10'($urandom_range(1, 24));
        if (roll < 85)
            return 10'($urandom_range(25, 128));
        return 10'($urandom_range(129, 512));
    endfunction

    function automatic logic [23:0] pick_zoom();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return 24'd0;
        if (roll < 14)
            return 24'hFF_FFFF;
        if (roll < 24)
            return 24'h01_0000;
        return 24'($urandom_range(24'h00_2000, 24'h03_0000));
    endfunction

    // One request transfer, after a random gap
    task automatic push_req(input req_t item);
        int gap;
        bit taken;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
        begin
            @(negedge clk);
            taken = req_ready;
            @(posedge clk);
        end
        while (!taken);
        if (item.func == FUNC_READ)
            reads_sent++;
        else
            src_written[{item.row, item.col}] = 1'b1;
        phase_items++;
    endtask

    // One register write transfer; upper data bits beyond the field are noise
    task automatic write_reg(input cfg_index_t idx, input logic [23:0] val);
        int gap;
        bit taken;
        gap = pick_gap();
        if (gap > 0)
        begin
            cfg_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        case (idx)
            CFG_INV_ZOOM_X:   live_cfg.inv_zoom_x   = val;
            CFG_INV_ZOOM_Y:   live_cfg.inv_zoom_y   = val;
            CFG_ROI_LEFT:     live_cfg.roi_left     = val[8:0];
            CFG_ROI_TOP:      live_cfg.roi_top      = val[8:0];
            CFG_ROI_RIGHT:    live_cfg.roi_right    = val[8:0];
            CFG_ROI_BOTTOM:   live_cfg.roi_bottom   = val[8:0];
            CFG_IMAGE_WIDTH:  live_cfg.image_width  = val[9:0];
            CFG_IMAGE_HEIGHT: live_cfg.image_height = val[9:0];
            default: ;
        endcase
    endtask

    // Wait until every requested pixel is back and the pipeline is empty
    task automatic drain();
        req_valid <= 1'b0;
        while (pixels_back != reads_sent)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [23:0] ix, input logic [23:0] iy,
                                  input logic [8:0] left, input logic [8:0] top,
                                  input logic [8:0] right, input logic [8:0] bottom,
                                  input logic [9:0] wid, input logic [9:0] hgt);
        drain();
        write_reg(CFG_INV_ZOOM_X, ix);
        write_reg(CFG_INV_ZOOM_Y, iy);
        write_reg(CFG_ROI_LEFT, {15'($urandom()), left});
        write_reg(CFG_ROI_TOP, {15'($urandom()), top});
        write_reg(CFG_ROI_RIGHT, {15'($urandom()), right});
        write_reg(CFG_ROI_BOTTOM, {15'($urandom()), bottom});
        write_reg(CFG_IMAGE_WIDTH, {14'($urandom()), wid});
        write_reg(CFG_IMAGE_HEIGHT, {14'($urandom()), hgt});
        cfg_valid <= 1'b0;
    endtask

    task automatic random_settings();
        logic [9:0] wid;
        logic [9:0] hgt;
        logic [8:0] left;
        logic [8:0] top;
        logic [8:0] right;
        logic [8:0] bottom;
        wid    = pick_size();
        hgt    = pick_size();
        left   = $urandom_range(0, 1) ? 9'd0 : 9'($urandom_range(0, eff_size(wid) - 1));
        top    = $urandom_range(0, 1) ? 9'd0 : 9'($urandom_range(0, eff_size(hgt) - 1));
        right  = $urandom_range(0, 1) ? 9'd511 : 9'($urandom_range(left, 511));
        bottom = $urandom_range(0, 1) ? 9'd511 : 9'($urandom_range(top, 511));
        apply_settings(pick_zoom(), pick_zoom(), left, top, right, bottom, wid, hgt);
    endtask

    task automatic send_write(input logic [8:0] c, input logic [8:0] r, input logic [7:0] pix);
        req_t item;
        item.func     = FUNC_WRITE;
        item.col      = c;
        item.row      = r;
        item.pixel_in = pix;
        push_req(item);
    endtask

    task automatic cover_source(input int x, input int y);
        if (!src_written[{9'(y), 9'(x)}])
            send_write(9'(x), 9'(y), 8'($urandom()));
    endtask

    // Read request; the four source neighbors it touches are written first
    task automatic send_read(input logic [8:0] c, input logic [8:0] r);
        req_t            item;
        int              w;
        int              h;
        int              right;
        int              bottom;
        longint unsigned sx;
        longint unsigned sy;
        int              xi;
        int              yi;
        int              xn;
        int              yn;
        w      = eff_size(live_cfg.image_width);
        h      = eff_size(live_cfg.image_height);
        right  = (int'(live_cfg.roi_right) < w - 1) ? int'(live_cfg.roi_right) : w - 1;
        bottom = (int'(live_cfg.roi_bottom) < h - 1) ? int'(live_cfg.roi_bottom) : h - 1;
        if (int'(c) >= int'(live_cfg.roi_left) && int'(c) <= right &&
            int'(r) >= int'(live_cfg.roi_top) && int'(r) <= bottom)
        begin
            sx = longint'(c) * longint'(live_cfg.inv_zoom_x);
            sy = longint'(r) * longint'(live_cfg.inv_zoom_y);
            xi = int'(sx >> 16);
            yi = int'(sy >> 16);
            if (xi <= w - 1 && yi <= h - 1)
            begin
                xn = (xi + 1 > w - 1) ? w - 1 : xi + 1;
                yn = (yi + 1 > h - 1) ? h - 1 : yi + 1;
                cover_source(xi, yi);
                cover_source(xn, yi);
                cover_source(xi, yn);
                cover_source(xn, yn);
            end
        end
        item.func     = FUNC_READ;
        item.col      = c;
        item.row      = r;
        item.pixel_in = 8'($urandom());
        push_req(item);
    endtask

    // Mostly reads near the image, some writes inside it, some noise
    task automatic random_item();
        int w;
        int h;
        int roll;
        w    = eff_size(live_cfg.image_width);
        h    = eff_size(live_cfg.image_height);
        roll = $urandom_range(0, 99);
        if (roll < 55)
            send_read(9'($urandom_range(0, (w + 2 > 511) ? 511 : w + 2)),
                      9'($urandom_range(0, (h + 2 > 511) ? 511 : h + 2)));
        else if (roll < 85)
            send_write(9'($urandom_range(0, w - 1)), 9'($urandom_range(0, h - 1)),
                       8'($urandom()));
        else if (roll < 93)
            send_read(9'($urandom()), 9'($urandom()));
        else
            send_write(9'($urandom()), 9'($urandom()), 8'($urandom()));
    endtask

    // Stimulus and verdict
    initial
    begin : stimulus
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        run_done  <= 1'b0;
        live_cfg.inv_zoom_x   = RST_INV_ZOOM;
        live_cfg.inv_zoom_y   = RST_INV_ZOOM;
        live_cfg.roi_left     = RST_ROI_LO;
        live_cfg.roi_top      = RST_ROI_LO;
        live_cfg.roi_right    = RST_ROI_HI;
        live_cfg.roi_bottom   = RST_ROI_HI;
        live_cfg.image_width  = RST_IMG_SIZE;
        live_cfg.image_height = RST_IMG_SIZE;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: corners, neighbors clamped at both far edges
        send_write(9'd0, 9'd0, 8'd255);
        send_write(9'd511, 9'd511, 8'd0);
        send_read(9'd0, 9'd0);
        send_read(9'd511, 9'd511);
        send_read(9'd0, 9'd511);
        send_read(9'd511, 9'd0);

        // half-step x, 1.5 step y on an 8x8 image, region starts at column 1
        apply_settings(24'h00_8000, 24'h01_8000, 9'd1, 9'd0, 9'd511, 9'd511, 10'd8, 10'd8);
        send_read(9'd0, 9'd0);  // left of the region
        send_read(9'd3, 9'd2);  // half-way blend in x
        send_read(9'd1, 9'd3);  // fractions in both axes
        send_read(9'd7, 9'd5);  // lower neighbor clamped to the last row
        send_read(9'd7, 9'd6);  // source row past the image
        send_read(9'd8, 9'd0);  // right of the clamped region

        // random phases; the first three pin the extreme settings
        for (int k = 0; k < 12; k++)
        begin
            case (k)
                0: apply_settings(24'd0, 24'd0, 9'd0, 9'd0, 9'd511, 9'd511,
                                  10'd1023, 10'd0);
                1: apply_settings(24'hFF_FFFF, 24'hFF_FFFF, 9'd0, 9'd0, 9'd511, 9'd511,
                                  10'd512, 10'd512);
                2: apply_settings(pick_zoom(), pick_zoom(), 9'd511, 9'd0, 9'd0, 9'd511,
                                  10'd64, 10'd64);
                default: random_settings();
            endcase
            steady_phase = ($urandom_range(0, 3) == 0);
            phase_items  = 0;
            while (phase_items < 150)
                random_item();
        end

        drain();
        run_done <= 1'b1;
        repeat (2) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: bilinear_image_zoom_unit.f
hdl/bizu_pkg.sv
hdl/bizu_ram.sv
hdl/bizu_cfg.sv
hdl/bizu_addr.sv
hdl/bizu_blend.sv
hdl/bilinear_image_zoom_unit.sv
verif/bizu_zoom_checker.sv
verif/tb_top.sv
